// ===== rtl/core/bbs_pkg.sv =====
`default_nettype none

package bbs_pkg;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_START  = 2'd1,
      ACT_STOP   = 2'd2,
      ACT_VOLUME = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_BEEP_TICKS   = 2'd0,
      REG_PAUSE_TICKS  = 2'd1,
      REG_DUTY_FLOOR   = 2'd2,
      REG_DUTY_CEILING = 2'd3
   } reg_index_type;

   localparam int unsigned TICK_W  = 16;
   localparam int unsigned DUTY_W  = 8;
   localparam int unsigned COUNT_W = 8;

   localparam logic [TICK_W-1:0] BEEP_TICKS_RESET   = 16'd500;
   localparam logic [TICK_W-1:0] PAUSE_TICKS_RESET  = 16'd500;
   localparam logic [DUTY_W-1:0] DUTY_FLOOR_RESET   = 8'd16;
   localparam logic [DUTY_W-1:0] DUTY_CEILING_RESET = 8'd128;

   typedef struct packed {
      logic               running;
      logic               sounding;
      logic               tone;
      logic [COUNT_W-1:0] done_count;
      logic [COUNT_W-1:0] target_count;
      logic [TICK_W-1:0]  elapsed;
      logic [DUTY_W-1:0]  volume;
   } seq_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/beep_burst_sequencer.sv =====
`default_nettype none

// Buzzer beep-burst sequencer. Each request carries an action in req_tuser (tick, start burst,
// stop, set volume) and produces exactly one response showing the state after that action:
// PWM duty, tone flag, busy flag and tones completed. A request is registered on entry and
// then evaluated straight into the response register, so one request per clock is
// sustained while the output is not stalled; each response is presented from the response
// register, behind the input register, and is held until it is taken. The tick/phase
// compare and the duty clamp are combinational between the input and response registers.
// A burst alternates beep_ticks tone phases with pause_ticks pauses, starting with a tone
// and ending after the last tone. Configuration writes take effect immediately and do not
// re-clamp the present volume.
module beep_burst_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] beep_count, [15:8] volume_request
   input  wire logic [1:0]  req_tuser,   // [1:0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] pwm_duty, [8] tone_on, [9] busy_res,
                                         // [17:10] beeps_done, [23:18] zero
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int unsigned TW = bbs_pkg::TICK_W;
   localparam int unsigned DW = bbs_pkg::DUTY_W;
   localparam int unsigned CW = bbs_pkg::COUNT_W;

   // configuration
   logic [TW-1:0] beep_ticks_ff;
   logic [TW-1:0] pause_ticks_ff;
   logic [DW-1:0] duty_floor_ff;
   logic [DW-1:0] duty_ceiling_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beep_ticks_ff   <= bbs_pkg::BEEP_TICKS_RESET;
         pause_ticks_ff  <= bbs_pkg::PAUSE_TICKS_RESET;
         duty_floor_ff   <= bbs_pkg::DUTY_FLOOR_RESET;
         duty_ceiling_ff <= bbs_pkg::DUTY_CEILING_RESET;
      end else if (csr_we) begin
         case (bbs_pkg::reg_index_type'(csr_index))
            bbs_pkg::REG_BEEP_TICKS:   beep_ticks_ff   <= csr_wdata;
            bbs_pkg::REG_PAUSE_TICKS:  pause_ticks_ff  <= csr_wdata;
            bbs_pkg::REG_DUTY_FLOOR:   duty_floor_ff   <= csr_wdata[DW-1:0];
            bbs_pkg::REG_DUTY_CEILING: duty_ceiling_ff <= csr_wdata[DW-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic                 in_valid_ff;
   bbs_pkg::action_type  in_action_ff;
   logic [CW-1:0]        in_count_ff;
   logic [DW-1:0]        in_volume_ff;
   logic                 advance;

   assign advance    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_action_ff <= bbs_pkg::action_type'(req_tuser);
         in_count_ff  <= req_tdata[7:0];
         in_volume_ff <= req_tdata[15:8];
      end
   end

   // sequencer state
   bbs_pkg::seq_state_type st_ff;
   bbs_pkg::seq_state_type st_in;
   logic [TW-1:0]          elapsed_inc;
   logic [CW-1:0]          done_inc;
   logic [DW-1:0]          raised;

   always_comb begin
      elapsed_inc = (st_ff.elapsed == {TW{1'b1}}) ? st_ff.elapsed : st_ff.elapsed + 1'b1;
      done_inc    = (st_ff.done_count == {CW{1'b1}}) ? st_ff.done_count
                                                     : st_ff.done_count + 1'b1;
      raised      = (in_volume_ff < duty_floor_ff) ? duty_floor_ff : in_volume_ff;
      st_in       = st_ff;
      case (in_action_ff)
         bbs_pkg::ACT_TICK: begin
            if (st_ff.running) begin
               st_in.elapsed = elapsed_inc;
               if (st_ff.sounding) begin
                  if (elapsed_inc >= beep_ticks_ff) begin
                     st_in.tone       = 1'b0;
                     st_in.done_count = done_inc;
                     if (done_inc >= st_ff.target_count) begin
                        st_in.running = 1'b0;
                     end else begin
                        st_in.sounding = 1'b0;
                        st_in.elapsed  = '0;
                     end
                  end
               end else if (elapsed_inc >= pause_ticks_ff) begin
                  st_in.tone     = 1'b1;
                  st_in.sounding = 1'b1;
                  st_in.elapsed  = '0;
               end
            end
         end
         bbs_pkg::ACT_START: begin
            if (in_count_ff != '0) begin
               st_in.running      = 1'b1;
               st_in.target_count = in_count_ff;
               st_in.done_count   = '0;
               st_in.sounding     = 1'b1;
               st_in.elapsed      = '0;
               st_in.tone         = 1'b1;
            end
         end
         bbs_pkg::ACT_STOP: begin
            if (st_ff.running) begin
               st_in.tone         = 1'b0;
               st_in.running      = 1'b0;
               st_in.sounding     = 1'b0;
               st_in.done_count   = '0;
               st_in.target_count = '0;
               st_in.elapsed      = '0;
            end
         end
         bbs_pkg::ACT_VOLUME: begin
            st_in.volume = (raised > duty_ceiling_ff) ? duty_ceiling_ff : raised;
         end
         default: ;
      endcase
   end

   // response register
   logic [23:0] rsp_data_in;
   logic [23:0] rsp_data_ff;
   logic        rsp_valid_ff;

   assign rsp_data_in = {6'd0, st_in.done_count, st_in.running, st_in.tone,
                         st_in.tone ? st_in.volume : {DW{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.running      <= 1'b0;
         st_ff.sounding     <= 1'b0;
         st_ff.tone         <= 1'b0;
         st_ff.done_count   <= '0;
         st_ff.target_count <= '0;
         st_ff.elapsed      <= '0;
         st_ff.volume       <= bbs_pkg::DUTY_CEILING_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (advance) begin
            st_ff <= st_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_tone_needs_run: assert property (@(posedge clock) disable iff (reset)
      st_ff.tone |-> st_ff.running)
      else $error("tone sounding outside a burst");

   a_done_below_target: assert property (@(posedge clock) disable iff (reset)
      st_ff.running |-> (st_ff.done_count < st_ff.target_count))
      else $error("burst running past its target count");

   a_stop_idles: assert property (@(posedge clock) disable iff (reset)
      (advance && in_action_ff == bbs_pkg::ACT_STOP) |=> (!st_ff.running && !st_ff.tone))
      else $error("stop left the burst active");

   a_duty_needs_tone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[7:0] != 8'd0) |-> rsp_tdata[8])
      else $error("nonzero duty with tone off");

endmodule

`default_nettype wire
